// ===== rtl/core/kiss_frame_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// KISS frame decoder assertion macros
// Concurrent assertion wrappers clocked on i_clk and disabled during reset.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef KISS_FRAME_DECODER_CORE_ASSERT_SVH
`define KISS_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked at every enabled clock edge.
`define KFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication form: the consequent must hold in the cycle after the antecedent.
`define KFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define KFD_ASSERT(label, prop, msg)
`define KFD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/kfd_pkg.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder package
// Shared constants, result kinds and transfer types of the decoder.
// ----------------------------------------------------------------------------
package kfd_pkg;

    localparam int LENGTH_BITS_DEF      = 16;
    localparam int MAX_PAYLOAD_W        = 16;
    localparam int MAX_PAYLOAD_RESET    = 1024;

    // Framing bytes.
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // Result kinds.
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } t_result;

    // Up to two results caused by one received byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

// ===== rtl/core/kfd_decoder.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder: framing state and byte decode
// Holds the frame state and turns one received byte into up to two results.
// ----------------------------------------------------------------------------
module kfd_decoder #(
    parameter  int LENGTH_BITS = kfd_pkg::LENGTH_BITS_DEF,
    localparam int MpW = (LENGTH_BITS < kfd_pkg::MAX_PAYLOAD_W) ?
                         LENGTH_BITS : kfd_pkg::MAX_PAYLOAD_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic [MpW-1:0]     i_max_payload,
    output kfd_pkg::t_dec_out  o_dec
);
    import kfd_pkg::*;

    localparam int CntW = LENGTH_BITS + 1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_CMD     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase            r_phase, n_phase;
    logic              r_esc, n_esc;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic              r_seen, n_seen;

    logic [CntW-1:0]   cnt_inc;
    logic [CntW:0]     limit;
    logic              over_inc;
    logic              pre_v;
    logic              main_v;
    t_result           main_res;
    t_result           esc_res;

    assign cnt_inc  = (r_cnt == '1) ? r_cnt : r_cnt + CntW'(1);
    assign limit    = (CntW+1)'(i_max_payload) + (CntW+1)'(2);
    assign over_inc = r_ovf || ((CntW+1)'(cnt_inc) > limit);
    assign esc_res  = '{data: FESC, kind: KIND_DATA};

    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_seen   = r_seen;
        pre_v    = 1'b0;
        main_v   = 1'b0;
        main_res = '{data: i_byte, kind: KIND_DATA};
        unique case (r_phase)
            PH_CMD: begin
                n_cnt   = cnt_inc;
                n_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_esc = 1'b0;
                if (r_esc && (i_byte == TFEND || i_byte == TFESC)) begin
                    n_cnt    = cnt_inc;
                    n_ovf    = over_inc;
                    n_seen   = 1'b1;
                    main_v   = !over_inc;
                    main_res = '{data: (i_byte == TFEND) ? FEND : FESC, kind: KIND_DATA};
                end else begin
                    // A lone escape is passed on as data before this byte.
                    pre_v = r_esc && !r_ovf;
                    if (i_byte == FEND) begin
                        main_v   = r_seen;
                        main_res = '{data: 8'h00,
                                     kind: r_ovf ? KIND_OVERFLOW : KIND_GOOD};
                        n_phase  = PH_HUNT;
                    end else begin
                        n_cnt  = cnt_inc;
                        n_ovf  = over_inc;
                        n_seen = 1'b1;
                        n_esc  = (i_byte == FESC);
                        main_v = (i_byte != FESC) && !over_inc;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_byte == FEND) begin
                    n_phase = PH_CMD;
                    n_esc   = 1'b0;
                    n_cnt   = CntW'(1);
                    n_ovf   = 1'b0;
                    n_seen  = 1'b0;
                end
            end
        endcase
    end

    always_comb begin
        o_dec = '0;
        if (pre_v) begin
            o_dec.res0  = esc_res;
            o_dec.res1  = main_res;
            o_dec.count = main_v ? 2'd2 : 2'd1;
        end else begin
            o_dec.res0  = main_res;
            o_dec.count = main_v ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_esc   <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_seen  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_seen  <= n_seen;
        end
    end

endmodule

// ===== rtl/core/kfd_result_buf.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder result register
// Holds the results of one byte and hands them out one transaction at a time.
// ----------------------------------------------------------------------------
module kfd_result_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  kfd_pkg::t_dec_out  i_dec,
    output logic               o_load_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kfd_pkg::t_result   o_result,
    output logic               o_last
);
    import kfd_pkg::*;

    t_result     r_res0, r_res1;
    logic [1:0]  r_cnt;
    logic        r_sel;
    logic        take;

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_result     = r_sel ? r_res1 : r_res0;
    assign o_last       = r_sel || (r_cnt == 2'd1);
    assign take         = o_out_valid && i_out_ready;
    assign o_load_ready = !o_out_valid || (take && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_sel <= 1'b0;
        end else if (i_load) begin
            r_cnt <= i_dec.count;
            r_sel <= 1'b0;
        end else if (take) begin
            if (o_last) begin
                r_cnt <= 2'd0;
                r_sel <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_dec.res0;
            r_res1 <= i_dec.res1;
        end
    end

endmodule

// ===== rtl/core/kiss_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder core
// The decoder takes one received byte per input transaction, hunts for an
// opening delimiter, drops the command byte and unescapes the payload. It
// issues one result transaction per decoded byte and one end transaction per
// non-empty frame (good, or overflow when the raw frame, delimiters and
// command byte included, is longer than max_payload plus three bytes; bytes
// past that point are dropped). A byte enters an input register, is decoded
// in a single pass into a result register holding up to two results, and the
// results leave one per cycle unless i_out_ready holds them. With no
// back-pressure, a byte that yields at most one result lets a new byte be
// accepted every cycle; a byte that yields two results (a lone escape followed
// by another byte) holds the input side while the output port serializes the
// pair. A byte passes the input register and then the result register before
// its first result appears. max_payload is written through i_cfg_we and
// i_cfg_data and must only change while the decoder is idle.
// ----------------------------------------------------------------------------
`include "kiss_frame_decoder_core_assert.svh"

module kiss_frame_decoder_core #(
    parameter int LENGTH_BITS = kfd_pkg::LENGTH_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write.
    input  logic                              i_cfg_we,
    input  logic [kfd_pkg::MAX_PAYLOAD_W-1:0] i_cfg_data,
    // Received byte channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_rx_byte,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_out_byte,
    output logic [1:0]                        o_kind,
    output logic                              o_last_of_run
);
    import kfd_pkg::*;

    // Only the low MpW bits of the written limit (the lesser of LENGTH_BITS and MAX_PAYLOAD_W) take part.
    localparam int MpW = (LENGTH_BITS < MAX_PAYLOAD_W) ? LENGTH_BITS : MAX_PAYLOAD_W;

    logic [MpW-1:0]  r_max_payload;
    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            advance;
    logic            buf_ready;
    t_dec_out        dec;
    t_result         out_res;

    // The limit register is written directly; there is no read-back path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MpW'(MAX_PAYLOAD_RESET);
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data[MpW-1:0];
        end
    end

    // Input register. It moves on whenever the result register can take the
    // decoded results of the byte it holds, so a new transaction is accepted
    // in the same cycle as the held byte is decoded.
    assign advance    = r_in_valid && buf_ready;
    assign o_in_ready = !r_in_valid || buf_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Framing state and single-pass decode of the held byte.
    kfd_decoder #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_dec         (dec)
    );

    // Result register: delivers the one or two results of a byte in order.
    kfd_result_buf u_result_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance),
        .i_dec        (dec),
        .o_load_ready (buf_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (out_res),
        .o_last       (o_last_of_run)
    );

    assign o_out_byte = out_res.data;
    assign o_kind     = out_res.kind;

    // A held byte that cannot be decoded yet must stay in the input register.
    `KFD_ASSERT_NEXT(a_in_hold, r_in_valid && !advance,
        r_in_valid && (r_in_byte == $past(r_in_byte)), "input byte lost while stalled")

    // An end-of-frame result is always the last result of its byte.
    `KFD_ASSERT(a_end_is_last, !o_out_valid || o_kind == KIND_DATA || o_last_of_run,
        "end result not marked last")

    // Two results from one byte only arise from a flushed lone escape.
    `KFD_ASSERT(a_pair_escape,
        !(advance && dec.count == 2'd2) ||
        (dec.res0.kind == KIND_DATA && dec.res0.data == FESC),
        "result pair does not start with an escape byte")

endmodule

// ===== tb/sv/tb_kiss_frame_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// KISS frame decoder core testbench
// Streams received bytes into the decoder and checks every result against a
// behavioral model of the frame decoding held in this file. Directed frames
// cover the escape sequences, a command byte equal to the frame delimiter,
// empty frames, a lone escape before another byte and before the closing
// delimiter, and a payload limit of zero. Random traffic follows under
// several payload limits with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_kiss_frame_decoder_core;
    import kfd_pkg::*;

    // Frame delimiter, command byte and closing delimiter around the payload.
    localparam int FRAME_OVERHEAD = 3;
    // Cycles allowed after the last result for a byte that is still in flight.
    localparam int SETTLE_CYCLES = 6;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_COMMAND = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_frame_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_dec_result;

    typedef logic [7:0] t_byte_q[$];

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic [7:0]  in_byte    = '0;
    logic        out_ready  = 1'b1;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic        o_last_of_run;

    // Traffic control shared by the stimulus, the driver and the monitor.
    t_byte_q     rx_pending;
    t_dec_result expected_results[$];
    logic        idle_on  = 1'b1;
    logic        out_hold = 1'b0;
    int          n_pushed   = 0;
    int          n_accepted = 0;
    int          n_errors   = 0;
    int          n_data     = 0;
    int          n_good     = 0;
    int          n_overflow = 0;
    int          n_limits   = 0;
    int          tx_gap     = 0;
    int          tx_calm    = 0;
    int          rx_stall   = 0;
    int          rx_calm    = 0;

    // Decoder state as the model sees it.
    logic [15:0]  max_payload = 16'(MAX_PAYLOAD_RESET);
    t_frame_phase dec_phase   = PH_HUNT;
    logic         esc_pend    = 1'b0;
    logic [16:0]  raw_count   = '0;
    logic         overflowed  = 1'b0;
    logic         payload_seen = 1'b0;

    kiss_frame_decoder_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // A payload byte adds one to the raw frame length, which saturates. The
    // frame overflows once that length passes max_payload plus two, since the
    // closing delimiter is not yet counted.
    task automatic count_payload_byte();
        if (raw_count != '1) raw_count = raw_count + 17'd1;
        if (int'(raw_count) > int'(max_payload) + FRAME_OVERHEAD - 1) overflowed = 1'b1;
        payload_seen = 1'b1;
    endtask

    // Works out the results that one accepted byte causes and queues them in
    // delivery order. The last of them carries the last_of_run flag.
    task automatic decode_rx_byte(input logic [7:0] b);
        t_dec_result run[$];
        t_dec_result r;
        logic        handled;
        handled = 1'b0;
        if (dec_phase == PH_COMMAND) begin
            // The command byte is dropped, whatever its value.
            if (raw_count != '1) raw_count = raw_count + 17'd1;
            dec_phase = PH_PAYLOAD;
        end else if (dec_phase == PH_PAYLOAD) begin
            if (esc_pend) begin
                esc_pend = 1'b0;
                if (b == TFEND || b == TFESC) begin
                    count_payload_byte();
                    if (!overflowed) run.push_back('{(b == TFEND) ? FEND : FESC, KIND_DATA, 1'b0});
                    handled = 1'b1;
                end else if (!overflowed) begin
                    // A lone escape goes out as data before the next byte.
                    run.push_back('{FESC, KIND_DATA, 1'b0});
                end
            end
            if (!handled) begin
                if (b == FEND) begin
                    if (payload_seen)
                        run.push_back('{8'h00, overflowed ? KIND_OVERFLOW : KIND_GOOD, 1'b0});
                    dec_phase = PH_HUNT;
                    esc_pend  = 1'b0;
                end else begin
                    count_payload_byte();
                    if (b == FESC) begin
                        esc_pend = 1'b1;
                    end else if (!overflowed) begin
                        run.push_back('{b, KIND_DATA, 1'b0});
                    end
                end
            end
        end else begin
            dec_phase = PH_HUNT;
            if (b == FEND) begin
                dec_phase    = PH_COMMAND;
                esc_pend     = 1'b0;
                raw_count    = 17'd1;
                overflowed   = 1'b0;
                payload_seen = 1'b0;
            end
        end
        if (run.size() != 0) run[run.size() - 1].last = 1'b1;
        foreach (run[k]) begin
            r = run[k];
            expected_results.push_back(r);
        end
    endtask

    // Driver: offers the oldest pending byte and holds it until the decoder
    // takes it. Idle gaps are only inserted between transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                decode_rx_byte(in_byte);
                n_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (idle_on && tx_calm == 0 && $urandom_range(0, 7) == 0) begin
                    tx_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    in_valid <= 1'b1;
                    in_byte  <= rx_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            // Now and then a calm stretch with no idling at all.
            if (tx_calm > 0) tx_calm--;
            else if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(10, 60);
        end
    end

    // Monitor: compares each result transaction with the oldest expectation
    // and drives the result-side ready with its own idle bursts.
    always @(posedge i_clk) begin
        t_dec_result exp_r;
        if (!i_rst_n) begin
            out_ready <= 1'b1;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: out_byte %02h kind %0d last_of_run %0b",
                           o_out_byte, o_kind, o_last_of_run);
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_out_byte !== exp_r.data) begin
                        $error("out_byte: expected %02h, actual %02h", exp_r.data, o_out_byte);
                        n_errors++;
                    end
                    if (o_kind !== exp_r.kind) begin
                        $error("kind: expected %0d, actual %0d", exp_r.kind, o_kind);
                        n_errors++;
                    end
                    if (o_last_of_run !== exp_r.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               exp_r.last, o_last_of_run);
                        n_errors++;
                    end
                    case (exp_r.kind)
                        KIND_DATA: n_data++;
                        KIND_GOOD: n_good++;
                        default:   n_overflow++;
                    endcase
                end
            end
            if (out_hold) begin
                out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else if (idle_on && rx_calm == 0 && $urandom_range(0, 7) == 0) begin
                rx_stall = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
            if (rx_calm > 0) rx_calm--;
            else if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(10, 60);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        n_pushed++;
    endtask

    task automatic send_seq(input t_byte_q seq);
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    // One frame with a random command byte and len raw payload positions.
    // Most positions are plain bytes or proper escape pairs; a few are lone
    // escapes, and a stray delimiter now and then closes the frame early.
    task automatic send_random_frame(input int len);
        int          sel;
        logic [7:0]  b;
        send_byte(FEND);
        send_byte(8'($urandom_range(0, 255)));
        for (int k = 0; k < len; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                send_byte(FESC);
                send_byte($urandom_range(0, 1) ? TFEND : TFESC);
            end else if (sel < 16) begin
                send_byte(FESC);
                send_byte(8'($urandom_range(0, 255)));
            end else if (sel < 17) begin
                send_byte(FEND);
            end else begin
                do b = 8'($urandom_range(0, 255)); while (b == FEND || b == FESC);
                send_byte(b);
            end
        end
        if ($urandom_range(0, 9) == 0) send_byte(FESC);
        send_byte(FEND);
    endtask

    // Occasional noise, then a frame of up to min(max_payload + 5, 40) positions.
    task automatic send_random_traffic();
        int len_cap;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        len_cap = (max_payload <= 16'd35) ? int'(max_payload) + 5 : 40;
        send_random_frame($urandom_range(0, len_cap));
    endtask

    // Returns once every byte has been taken and every result has arrived,
    // plus a settling wait of SETTLE_CYCLES for a byte that causes no result.
    task automatic wait_idle();
        while (n_accepted != n_pushed || expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_payload(input logic [15:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        max_payload = value;
        n_limits++;
    endtask

    // Stimulus: directed frames first, then random traffic under a range of
    // payload limits. The last limit runs without any idling.
    initial begin
        t_byte_q     dir_seq;
        logic [15:0] limits[$];
        int          seg_start;
        logic        paused;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Noise while hunting, a command byte equal to the delimiter, both
        // escape pairs, a lone escape before a plain byte and before the
        // closing delimiter, an empty frame, and an escape followed by an
        // escape.
        dir_seq = {8'h00, 8'hFF, FEND, FEND, 8'h00, 8'hFF, FESC, TFEND, FESC, TFESC,
                   FESC, 8'h41, FESC, FEND};
        send_seq(dir_seq);
        dir_seq = {FEND, 8'h7F, FEND, FEND, 8'h00, FESC, FESC, TFESC, FEND};
        send_seq(dir_seq);

        // A zero limit makes every payload byte overflow.
        write_max_payload(16'd0);
        dir_seq = {FEND, 8'h00, 8'h41, FESC, TFEND, FESC, FEND};
        send_seq(dir_seq);

        limits = {16'd1, 16'd2, 16'd5, 16'd16, 16'd3, 16'd300, 16'hFFFF, 16'd1024};
        foreach (limits[idx]) begin
            if (idx == limits.size() - 1) begin
                wait_idle();
                idle_on <= 1'b0;
            end
            write_max_payload(limits[idx]);
            seg_start = n_pushed;
            paused    = 1'b0;
            if (idx == 3) begin
                // Hold the result side off for a long stretch while the
                // sender keeps offering, so the decoder backs up its input.
                out_hold <= 1'b1;
                while (n_pushed - seg_start < 120) send_random_traffic();
                repeat (300) @(posedge i_clk);
                out_hold <= 1'b0;
            end
            if (idx == 5) send_random_frame(int'(max_payload) + 5);
            while (n_pushed - seg_start < 130) begin
                if (idx == 1 && !paused && n_pushed - seg_start >= 85) begin
                    // Sender pause in mid stream until every result is out.
                    wait_idle();
                    paused = 1'b1;
                end
                send_random_traffic();
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d received bytes under %0d payload limits: %0d data bytes,",
                 n_accepted, n_limits + 1, n_data);
        $display("%0d good frame ends and %0d overflow frame ends checked, %0d mismatches.",
                 n_good, n_overflow, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: 2 ms is far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
